// ===== rtl/cspl_pkg.sv =====
// ----------------------------------------------------------------------------
// cspl_pkg
// widths, fixed-point constants and register map of the cardinal spline unit
// ----------------------------------------------------------------------------
package cspl_pkg;

    // number formats
    localparam int T_FRAC_BITS    = 16;                  // position t in Q1.16
    localparam int TENS_FRAC_BITS = 14;                  // tension in Q2.14
    localparam int TENS_W         = 16;
    localparam int COORD_W        = 32;                  // Q16.16 coordinates
    localparam int HALF_W         = COORD_W / 2;         // coordinate split
    localparam int POS_W          = T_FRAC_BITS + 1;     // t up to and including 1.0

    // weight arithmetic
    localparam int W_FRAC = T_FRAC_BITS + TENS_FRAC_BITS; // weight fraction bits
    localparam int W_W    = W_FRAC + 3;                   // weights stay below 2^(W_FRAC+2)
    localparam int SC_W   = TENS_W + 3;                   // signed tension combinations
    localparam int TD_W   = POS_W + 3;                    // signed power differences
    localparam int PR_W   = SC_W + TD_W;                  // basis partial products
    localparam int HP_W   = W_W + HALF_W + 1;             // weight times coordinate half
    localparam int SUM_W  = HP_W + 2;                     // sum of four such products
    localparam int TOT_W  = SUM_W + HALF_W + 1;           // recombined dot product
    localparam int Q_W    = TOT_W - W_FRAC;               // scaled back, before saturation

    localparam int ONE_S = 1 << TENS_FRAC_BITS;

    localparam logic [POS_W-1:0] ONE_T = POS_W'(1) << T_FRAC_BITS;
    localparam logic [2*POS_W-1:0] T_RND = (2*POS_W)'(1) << (T_FRAC_BITS - 1);

    localparam logic signed [SC_W-1:0] S_TWO   = SC_W'(2 * ONE_S);
    localparam logic signed [SC_W-1:0] S_THREE = SC_W'(3 * ONE_S);
    localparam logic signed [PR_W-1:0] W_ONE   = PR_W'(1) << W_FRAC;
    localparam logic signed [TOT_W-1:0] Q_RND  = TOT_W'(1) << (W_FRAC - 1);

    localparam logic [TENS_W-1:0] TENSION_RST = TENS_W'(ONE_S / 2);

    // register map, index taken from paddr above the byte offset
    localparam int ADDR_W = 3;
    localparam logic REG_TENSION = 1'b0;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [W_W-1:0]     t_weight;
    typedef logic signed [PR_W-1:0]    t_part;

endpackage

// ===== rtl/cardinal_spline_eval.sv =====
// ----------------------------------------------------------------------------
// cardinal_spline_eval
// o_valid pulses when the item taken on start leaves the last register stage
// throughput: one evaluation per clock, busy never goes high, results never stall
// eight register stages: input, t^2, t^3, basis products, weights,
//   weight x coordinate products, sums, round and saturate
// reset (synchronous, i_rst_n low): pipeline emptied, tension back to 0.5
// ----------------------------------------------------------------------------
module cardinal_spline_eval
    import cspl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command side
    input  logic                 start,
    output logic                 busy,
    input  logic signed [31:0]   i_point_before,
    input  logic signed [31:0]   i_point_start,
    input  logic signed [31:0]   i_point_end,
    input  logic signed [31:0]   i_point_after,
    input  logic [POS_W-1:0]     i_position,
    // result side, one strobe per result transfer
    output logic                 o_valid,
    output logic signed [31:0]   o_value,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [TENS_W-1:0] r_tension;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TENSION);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tension <= TENSION_RST;
        end else if (cfg_wr) begin
            r_tension <= pwdata[TENS_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_TENSION) begin
            prdata = {{(32-TENS_W){1'b0}}, r_tension};
        end
    end

    // no back pressure anywhere: a new item every clock
    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // stage valid bits
    // ------------------------------------------------------------------
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_s6_vld, r_s7_vld;
    logic r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
            r_s7_vld <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_s1_vld <= accept;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
            r_s7_vld <= r_s6_vld;
            r_valid  <= r_s7_vld;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: capture, clamp t to 1.0, snapshot tension
    // ------------------------------------------------------------------
    logic [POS_W-1:0]  r_s1_p;
    logic [TENS_W-1:0] r_s1_s;
    t_coord            r_s1_c [4];
    logic [POS_W-1:0]  n_s1_p;

    assign n_s1_p = (i_position > ONE_T) ? ONE_T : i_position;

    always_ff @(posedge i_clk) begin
        r_s1_p    <= n_s1_p;
        r_s1_s    <= r_tension;
        r_s1_c[0] <= i_point_before;
        r_s1_c[1] <= i_point_start;
        r_s1_c[2] <= i_point_end;
        r_s1_c[3] <= i_point_after;
    end

    // ------------------------------------------------------------------
    // stage 2: t^2, rounded half up
    // ------------------------------------------------------------------
    logic [POS_W-1:0]   r_s2_p, r_s2_t2;
    logic [TENS_W-1:0]  r_s2_s;
    t_coord             r_s2_c [4];
    logic [2*POS_W-1:0] n_s2_sq;

    assign n_s2_sq = (r_s1_p * r_s1_p) + T_RND;

    always_ff @(posedge i_clk) begin
        r_s2_p  <= r_s1_p;
        r_s2_t2 <= n_s2_sq[T_FRAC_BITS +: POS_W];
        r_s2_s  <= r_s1_s;
        r_s2_c  <= r_s1_c;
    end

    // ------------------------------------------------------------------
    // stage 3: t^3 from the rounded t^2
    // ------------------------------------------------------------------
    logic [POS_W-1:0]   r_s3_p, r_s3_t2, r_s3_t3;
    logic [TENS_W-1:0]  r_s3_s;
    t_coord             r_s3_c [4];
    logic [2*POS_W-1:0] n_s3_cu;

    assign n_s3_cu = (r_s2_t2 * r_s2_p) + T_RND;

    always_ff @(posedge i_clk) begin
        r_s3_p  <= r_s2_p;
        r_s3_t2 <= r_s2_t2;
        r_s3_t3 <= n_s3_cu[T_FRAC_BITS +: POS_W];
        r_s3_s  <= r_s2_s;
        r_s3_c  <= r_s2_c;
    end

    // ------------------------------------------------------------------
    // stage 4: basis partial products, one multiplier per term
    // ------------------------------------------------------------------
    logic signed [SC_W-1:0] n_s, n_c1a, n_c1b, n_c2a, n_c2b;
    logic signed [TD_W-1:0] n_t1, n_t2, n_t3, n_d0, n_d3;
    t_part                  r_s4_m0, r_s4_m1a, r_s4_m1b, r_s4_m2a, r_s4_m2b, r_s4_m2c;
    t_part                  r_s4_m3;
    t_coord                 r_s4_c [4];

    always_comb begin
        n_s   = signed'({3'b000, r_s3_s});
        n_t1  = signed'({3'b000, r_s3_p});
        n_t2  = signed'({3'b000, r_s3_t2});
        n_t3  = signed'({3'b000, r_s3_t3});
        // before: s(2t^2 - t - t^3), after: s(t^3 - t^2)
        n_d0  = (n_t2 <<< 1) - n_t1 - n_t3;
        n_d3  = n_t3 - n_t2;
        // start: (2-s)t^3 + (s-3)t^2 + 1, end: (s-2)t^3 + (3-2s)t^2 + st
        n_c1a = S_TWO - n_s;
        n_c1b = n_s - S_THREE;
        n_c2a = n_s - S_TWO;
        n_c2b = S_THREE - (n_s <<< 1);
    end

    always_ff @(posedge i_clk) begin
        r_s4_m0  <= n_s * n_d0;
        r_s4_m1a <= n_c1a * n_t3;
        r_s4_m1b <= n_c1b * n_t2;
        r_s4_m2a <= n_c2a * n_t3;
        r_s4_m2b <= n_c2b * n_t2;
        r_s4_m2c <= n_s * n_t1;
        r_s4_m3  <= n_s * n_d3;
        r_s4_c   <= r_s3_c;
    end

    // ------------------------------------------------------------------
    // stage 5: weights, exact in Q.(t + tension) fraction bits
    // ------------------------------------------------------------------
    t_weight r_s5_w [4];
    t_coord  r_s5_c [4];
    t_part   n_s5_w1, n_s5_w2;

    assign n_s5_w1 = r_s4_m1a + r_s4_m1b + W_ONE;
    assign n_s5_w2 = r_s4_m2a + r_s4_m2b + r_s4_m2c;

    always_ff @(posedge i_clk) begin
        r_s5_w[0] <= W_W'(r_s4_m0);
        r_s5_w[1] <= W_W'(n_s5_w1);
        r_s5_w[2] <= W_W'(n_s5_w2);
        r_s5_w[3] <= W_W'(r_s4_m3);
        r_s5_c    <= r_s4_c;
    end

    // ------------------------------------------------------------------
    // stage 6: each coordinate split into a signed high half and an
    // unsigned low half, so every multiplier stays weight x 17 bits
    // ------------------------------------------------------------------
    logic signed [HP_W-1:0] r_s6_ph [4];
    logic signed [HP_W-1:0] r_s6_pl [4];
    logic signed [HALF_W-1:0] n_hi [4];
    logic signed [HALF_W:0]   n_lo [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_hi[k] = r_s5_c[k][COORD_W-1:HALF_W];
            n_lo[k] = signed'({1'b0, r_s5_c[k][HALF_W-1:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_s6_ph[k] <= r_s5_w[k] * n_hi[k];
            r_s6_pl[k] <= r_s5_w[k] * n_lo[k];
        end
    end

    // ------------------------------------------------------------------
    // stage 7: sum the high and low product sets
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] r_s7_hi, r_s7_lo;

    always_ff @(posedge i_clk) begin
        r_s7_hi <= SUM_W'(r_s6_ph[0]) + SUM_W'(r_s6_ph[1])
                 + SUM_W'(r_s6_ph[2]) + SUM_W'(r_s6_ph[3]);
        r_s7_lo <= SUM_W'(r_s6_pl[0]) + SUM_W'(r_s6_pl[1])
                 + SUM_W'(r_s6_pl[2]) + SUM_W'(r_s6_pl[3]);
    end

    // ------------------------------------------------------------------
    // stage 8: recombine, round half toward +inf, saturate to 32 bits
    // ------------------------------------------------------------------
    logic signed [TOT_W-1:0] n_tot;
    logic signed [Q_W-1:0]   n_q;
    logic signed [31:0]      n_value;
    logic signed [31:0]      r_value;
    logic                    n_in_range;

    always_comb begin
        n_tot      = (TOT_W'(r_s7_hi) <<< HALF_W) + TOT_W'(r_s7_lo) + Q_RND;
        n_q        = n_tot[TOT_W-1:W_FRAC];
        // in range when the sign bit and all bits above it agree
        n_in_range = (&n_q[Q_W-1:COORD_W-1]) || !(|n_q[Q_W-1:COORD_W-1]);
        if (n_in_range) begin
            n_value = n_q[COORD_W-1:0];
        end else if (n_q[Q_W-1]) begin
            n_value = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            n_value = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    logic signed [W_W+1:0] n_wsum;
    assign n_wsum = (W_W+2)'(r_s5_w[0]) + (W_W+2)'(r_s5_w[1])
                  + (W_W+2)'(r_s5_w[2]) + (W_W+2)'(r_s5_w[3]);

    // every accepted item gives exactly one result strobe at the end of the pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##8 o_valid)
        else $error("result strobe missing after accepted item");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 8))
        else $error("result strobe without a matching accepted item");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (r_s1_p <= ONE_T))
        else $error("position not clamped to 1.0");

    // cardinal weights always sum to exactly one
    a_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s5_vld |-> (n_wsum == (W_W+2)'(W_ONE)))
        else $error("basis weights do not sum to one");

endmodule
